// ===== hdl/prq_pkg.sv =====
//------------------------------------------------------------------------------
// prq_pkg: shared types and constants of the ready queue scheduler
// Action codes, status codes, state machine states, request and result payloads.
//------------------------------------------------------------------------------
`default_nettype none
package prq_pkg;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned IN_ID_W = 10;
	localparam int unsigned IN_PRIO_W = 6;
	localparam int unsigned WAKE_W = 63;
	localparam int unsigned TICK_W = 64;
	localparam int unsigned SLICE_W = 8;
	localparam int unsigned CNT_OUT_W = 7;
	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_UNBLOCK = 2'd0,
		ACT_SLEEP = 2'd1,
		ACT_TICK = 2'd2,
		ACT_DISPATCH = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_SCAN,
		S_INS_SHIFT,
		S_POP_SHIFT,
		S_SLP_READ,
		S_SLP_EVAL,
		S_WAKE_SCAN,
		S_WAKE_SHIFT,
		S_FINISH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [IN_ID_W-1:0] thread_id;
		logic [IN_PRIO_W-1:0] prio_level;
		logic [WAKE_W-1:0] wake_tick;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IN_ID_W-1:0] out_thread;
		logic [IN_PRIO_W-1:0] out_prio;
		logic idle;
		logic yield_request;
		logic [CNT_OUT_W-1:0] woken_count;
		logic [CNT_OUT_W-1:0] ready_count;
		logic [IN_PRIO_W-1:0] top_prio;
	} rsp_t;
endpackage
`default_nettype wire

// ===== hdl/prq_if.sv =====
//------------------------------------------------------------------------------
// prq_if: valid/ready channel
// Carries one payload item per transfer between a source and a sink.
//------------------------------------------------------------------------------
`default_nettype none
interface prq_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/priority_ready_queue_with_timed_wakeup_top.sv =====
//------------------------------------------------------------------------------
// priority_ready_queue_with_timed_wakeup_top: hardware thread scheduler
// Sorted ready queue and sleep table in single-port synchronous memories.
//------------------------------------------------------------------------------
// Channel   Dir  Payload
// req       in   action, thread_id, prio_level, wake_tick
// rsp       out  status, out_thread, out_prio, idle, yield_request,
//                woken_count, ready_count, top_prio
// cfg       in   cfg_we, cfg_wdata (slice limit)
//
// One item at a time. Unblock scans for the insert position, then ripples
// lower entries toward the tail; dispatch moves each entry toward the head;
// sleep writes one sleep entry; tick sweeps the sleep table and inserts each
// woken sleeper. Each ready step is a read-then-write on the ready memory,
// which holds one access a cycle. Reset clears state, counters and rsp valid;
// the memories need no clearing. The output register holds while rsp stalls;
// a new item is taken meanwhile; its result waits in S_OUT for a free register.
`default_nettype none
module priority_ready_queue_with_timed_wakeup_top #(
	parameter int unsigned QUEUE_DEPTH = 64,
	parameter int unsigned ID_WIDTH = 10,
	parameter int unsigned PRIO_MAX = 63
) (
	input wire logic clk,
	input wire logic arst_n,
	prq_if.sink req,
	prq_if.source rsp,
	input wire logic cfg_we,
	input wire logic [prq_pkg::SLICE_W-1:0] cfg_wdata
);
	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned PW = (PRIO_MAX > 1) ? $clog2(PRIO_MAX + 1) : 1;
	localparam int unsigned EW = ID_WIDTH + PW;
	localparam int unsigned SW = EW + prq_pkg::WAKE_W;
	localparam int unsigned IN_ID_W_L = prq_pkg::IN_ID_W;

	typedef struct packed {
		logic [ID_WIDTH-1:0] id;
		logic [PW-1:0] prio;
	} entry_t;

	// Memories.
	entry_t rdy_mem [QUEUE_DEPTH];
	logic [SW-1:0] slp_mem [QUEUE_DEPTH];
	entry_t rdy_rd_q;
	logic [SW-1:0] slp_rd_q;
	logic rdy_we, slp_we;
	logic [AW-1:0] rdy_addr, slp_addr;
	entry_t rdy_wd;
	logic [SW-1:0] slp_wd;

	always_ff @(posedge clk) begin
		if (rdy_we) rdy_mem[rdy_addr] <= rdy_wd;
		rdy_rd_q <= rdy_mem[rdy_addr];
	end
	always_ff @(posedge clk) begin
		if (slp_we) slp_mem[slp_addr] <= slp_wd;
		slp_rd_q <= slp_mem[slp_addr];
	end

	// Control state.
	prq_pkg::state_t state_q, state_d;
	logic [FW-1:0] rfill_q, rfill_d, sfill_q, sfill_d;
	logic [FW-1:0] pos_q, pos_d;   // scan index / shift index
	logic [FW-1:0] rd_q, rd_d, wr_q, wr_d;
	logic [prq_pkg::TICK_W-1:0] tick_q, tick_d;
	logic [prq_pkg::SLICE_W-1:0] slice_q, slice_d, tslice_q;
	logic [prq_pkg::CNT_OUT_W-1:0] woken_q, woken_d;
	logic phase_q, phase_d;        // 0: issue read, 1: data available
	logic wake_q, wake_d;          // insert came from a wakeup
	entry_t ins_q, ins_d;
	logic [prq_pkg::WAKE_W-1:0] wk_q, wk_d;
	prq_pkg::rsp_t res_q, res_d;
	prq_pkg::rsp_t out_q, out_d;
	logic rvalid_q, rvalid_d;

	// Request decode.
	entry_t req_e;
	logic [IN_ID_W_L-1:0] unused_id;
	always_comb begin
		logic [prq_pkg::IN_PRIO_W-1:0] p;
		p = req.data.prio_level;
		unused_id = req.data.thread_id;
		req_e.id = ID_WIDTH'(unused_id);
		if (32'(p) > PRIO_MAX) req_e.prio = PW'(PRIO_MAX);
		else req_e.prio = PW'(p);
	end

	assign req.ready = (state_q == prq_pkg::S_IDLE);
	assign rsp.valid = rvalid_q;
	assign rsp.data = out_q;

	// Slice limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tslice_q <= prq_pkg::SLICE_RESET;
		else if (cfg_we) tslice_q <= cfg_wdata;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prq_pkg::S_IDLE;
			rfill_q <= '0;
			sfill_q <= '0;
			tick_q <= '0;
			slice_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rfill_q <= rfill_d;
			sfill_q <= sfill_d;
			tick_q <= tick_d;
			slice_q <= slice_d;
			rvalid_q <= rvalid_d;
		end
	end
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		rd_q <= rd_d;
		wr_q <= wr_d;
		woken_q <= woken_d;
		phase_q <= phase_d;
		wake_q <= wake_d;
		ins_q <= ins_d;
		wk_q <= wk_d;
		res_q <= res_d;
		out_q <= out_d;
	end

	// Next state and memory control.
	always_comb begin
		state_d = state_q;
		rfill_d = rfill_q;
		sfill_d = sfill_q;
		pos_d = pos_q;
		rd_d = rd_q;
		wr_d = wr_q;
		tick_d = tick_q;
		slice_d = slice_q;
		woken_d = woken_q;
		phase_d = phase_q;
		wake_d = wake_q;
		ins_d = ins_q;
		wk_d = wk_q;
		res_d = res_q;
		out_d = out_q;
		rvalid_d = rvalid_q;
		rdy_we = 1'b0;
		rdy_addr = pos_q[AW-1:0];
		rdy_wd = ins_q;
		slp_we = 1'b0;
		slp_addr = rd_q[AW-1:0];
		slp_wd = {ins_q, wk_q};
		if (rvalid_q && rsp.ready) rvalid_d = 1'b0;
		unique case (state_q)
			prq_pkg::S_IDLE: begin
				res_d = '0;
				woken_d = '0;
				phase_d = 1'b0;
				wake_d = 1'b0;
				ins_d = req_e;
				wk_d = req.data.wake_tick;
				pos_d = '0;
				rd_d = '0;
				wr_d = '0;
				if (req.valid && req.ready) begin
					unique case (prq_pkg::action_t'(req.data.action))
						prq_pkg::ACT_UNBLOCK: begin
							if (32'(rfill_q) >= QUEUE_DEPTH) begin
								res_d.status = prq_pkg::ST_FULL;
								state_d = prq_pkg::S_FINISH;
							end else state_d = prq_pkg::S_INS_SCAN;
						end
						prq_pkg::ACT_SLEEP: begin
							if (32'(sfill_q) >= QUEUE_DEPTH) begin
								res_d.status = prq_pkg::ST_FULL;
							end else begin
								slp_we = 1'b1;
								slp_addr = sfill_q[AW-1:0];
								slp_wd = {req_e, req.data.wake_tick};
								sfill_d = sfill_q + 1'b1;
							end
							state_d = prq_pkg::S_FINISH;
						end
						prq_pkg::ACT_TICK: begin
							tick_d = tick_q + 1'b1;
							if (slice_q != '1) slice_d = slice_q + 1'b1;
							res_d.yield_request =
								((slice_q != '1) ? slice_q + 1'b1 : slice_q) >= tslice_q;
							state_d = prq_pkg::S_SLP_READ;
						end
						default: begin
							slice_d = '0;
							if (rfill_q == '0) begin
								res_d.status = prq_pkg::ST_EMPTY;
								res_d.idle = 1'b1;
								state_d = prq_pkg::S_FINISH;
							end else state_d = prq_pkg::S_POP_SHIFT;
						end
					endcase
				end
			end
			// Find the insert position: first entry with lower priority.
			prq_pkg::S_INS_SCAN: begin
				if (pos_q == rfill_q) begin
					rdy_we = 1'b1;
					rdy_addr = pos_q[AW-1:0];
					rdy_wd = ins_q;
					rfill_d = rfill_q + 1'b1;
					if (wake_q) woken_d = woken_q + 1'b1;
					state_d = wake_q ? prq_pkg::S_SLP_READ : prq_pkg::S_FINISH;
				end else if (!phase_q) begin
					rdy_addr = pos_q[AW-1:0];
					phase_d = 1'b1;
				end else begin
					phase_d = 1'b0;
					if (rdy_rd_q.prio >= ins_q.prio) pos_d = pos_q + 1'b1;
					else begin
						// Write the new entry, carry the displaced one onward.
						rdy_we = 1'b1;
						rdy_addr = pos_q[AW-1:0];
						rdy_wd = ins_q;
						ins_d = rdy_rd_q;
						pos_d = pos_q + 1'b1;
						state_d = prq_pkg::S_INS_SHIFT;
					end
				end
			end
			// Ripple displaced entries one place toward the tail.
			prq_pkg::S_INS_SHIFT: begin
				if (pos_q == rfill_q) begin
					rdy_we = 1'b1;
					rdy_addr = pos_q[AW-1:0];
					rdy_wd = ins_q;
					rfill_d = rfill_q + 1'b1;
					if (wake_q) woken_d = woken_q + 1'b1;
					state_d = wake_q ? prq_pkg::S_SLP_READ : prq_pkg::S_FINISH;
				end else if (!phase_q) begin
					rdy_addr = pos_q[AW-1:0];
					phase_d = 1'b1;
				end else begin
					phase_d = 1'b0;
					rdy_we = 1'b1;
					rdy_addr = pos_q[AW-1:0];
					rdy_wd = ins_q;
					ins_d = rdy_rd_q;
					pos_d = pos_q + 1'b1;
				end
			end
			// Pop: read each entry and write it one place toward the head.
			prq_pkg::S_POP_SHIFT: begin
				if (pos_q == rfill_q) begin
					rfill_d = rfill_q - 1'b1;
					state_d = prq_pkg::S_FINISH;
				end else if (!phase_q) begin
					rdy_addr = pos_q[AW-1:0];
					phase_d = 1'b1;
				end else begin
					phase_d = 1'b0;
					if (pos_q == '0) begin
						res_d.out_thread = prq_pkg::IN_ID_W'(rdy_rd_q.id);
						res_d.out_prio = prq_pkg::IN_PRIO_W'(rdy_rd_q.prio);
					end else begin
						rdy_we = 1'b1;
						rdy_addr = AW'(pos_q - 1'b1);
						rdy_wd = rdy_rd_q;
					end
					pos_d = pos_q + 1'b1;
				end
			end
			// Sleep table sweep with compaction.
			prq_pkg::S_SLP_READ: begin
				if (rd_q == sfill_q) begin
					sfill_d = wr_q;
					state_d = prq_pkg::S_FINISH;
				end else begin
					slp_addr = rd_q[AW-1:0];
					state_d = prq_pkg::S_SLP_EVAL;
				end
			end
			prq_pkg::S_SLP_EVAL: begin
				rd_d = rd_q + 1'b1;
				if ((tick_q >= {1'b0, slp_rd_q[prq_pkg::WAKE_W-1:0]})
						&& (32'(rfill_q) < QUEUE_DEPTH)) begin
					ins_d = slp_rd_q[SW-1 -: EW];
					wake_d = 1'b1;
					pos_d = '0;
					phase_d = 1'b0;
					state_d = prq_pkg::S_INS_SCAN;
				end else begin
					slp_we = 1'b1;
					slp_addr = wr_q[AW-1:0];
					slp_wd = slp_rd_q;
					wr_d = wr_q + 1'b1;
					state_d = prq_pkg::S_SLP_READ;
				end
			end
			// Read the head for top_prio.
			prq_pkg::S_FINISH: begin
				rdy_addr = '0;
				state_d = prq_pkg::S_OUT;
			end
			// Hand the result over once the output register is free.
			prq_pkg::S_OUT: begin
				rdy_addr = '0;
				if (!rvalid_q || rsp.ready) begin
					out_d = res_q;
					out_d.woken_count = woken_q;
					out_d.ready_count = prq_pkg::CNT_OUT_W'(rfill_q);
					out_d.top_prio = (rfill_q == '0) ? '0
						: prq_pkg::IN_PRIO_W'(rdy_rd_q.prio);
					rvalid_d = 1'b1;
					state_d = prq_pkg::S_IDLE;
				end
			end
			default: state_d = prq_pkg::S_IDLE;
		endcase
	end

	// Checks.
	a_rfill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rfill_q) <= QUEUE_DEPTH) else $error("ready fill over depth");
	a_sfill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sfill_q) <= QUEUE_DEPTH) else $error("sleep fill over depth");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != prq_pkg::S_IDLE) |-> !req.ready) else $error("accept while busy");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.idle) |-> (rsp.data.ready_count == '0))
		else $error("idle with nonempty queue");
endmodule
`default_nettype wire
